>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes of the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int VAL_W        = 32;
    localparam int PRIO_W       = 8;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // One slot of the queue as it moves between neighboring cells.
    typedef struct packed {
        logic                     valid;
        logic signed [VAL_W-1:0]  value;
        logic [PRIO_W-1:0]        prio;
    } t_entry;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [VAL_W-1:0]  value;
        logic [PRIO_W-1:0]        prio;
    } t_cell_ctrl;

endpackage

>>> rtl/spq_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the sorted priority queue: commands in, results out.
// Depends on spq_pkg for the field widths.
interface spq_cmd_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [VAL_W-1:0]  item_value;
    logic [PRIO_W-1:0]        item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [VAL_W-1:0]  head_value;
    logic [PRIO_W-1:0]        head_priority;
    logic signed [VAL_W-1:0]  removed_value;
    logic [PRIO_W-1:0]        removed_priority;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, status, head_value, head_priority, removed_value,
                    removed_priority, entry_count, is_empty, is_full, input ready);
    modport sink   (input valid, status, head_value, head_priority, removed_value,
                    removed_priority, entry_count, is_empty, is_full, output ready);
endinterface

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted queue: holds an entry, keeps it or takes the newcomer, its left
// neighbor or its right neighbor on each command. Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_before,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output spq_pkg::t_entry     o_next,
    output logic                o_before
);
    import spq_pkg::*;

    logic                     r_valid;
    logic signed [VAL_W-1:0]  r_value;
    logic [PRIO_W-1:0]        r_prio;
    t_entry                   n_entry;

    assign o_entry = '{valid: r_valid, value: r_value, prio: r_prio};

    // The newcomer lands at or ahead of this slot unless the slot holds an
    // entry of higher or equal priority (equal priorities stay in arrival order).
    assign o_before = !(r_valid && (r_prio >= i_ctrl.prio));

    always_comb begin
        n_entry = o_entry;
        if (i_ctrl.ins) begin
            if (o_before) begin
                if (i_left_before) begin
                    n_entry = i_left;
                end else begin
                    n_entry = '{valid: 1'b1, value: i_ctrl.value, prio: i_ctrl.prio};
                end
            end
        end else if (i_ctrl.rem) begin
            n_entry = i_right;
        end
    end

    assign o_next = n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_entry.value;
        r_prio  <= n_entry.prio;
    end

endmodule

>>> rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted priority queue of CAPACITY (value, priority) entries, highest priority
// at the head, equal priorities first in first out. Takes one command per clock
// while the result is taken or none waits: every slot compares the newcomer's
// priority in parallel and shifts by one in the same cycle, so the row of slot
// cells sets the rate. The result is registered at the transfer, and a new
// command is taken while that result waits only if it is taken in the same cycle.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_cmd_if.sink     i_cmd,
    spq_rsp_if.source   o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    t_entry     w_entry  [CAPACITY];
    t_entry     w_next   [CAPACITY];
    logic       w_before [CAPACITY];
    t_cell_ctrl w_ctrl;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_empty;
    logic             w_full;
    logic [STATUS_W-1:0] w_status;
    logic [31:0]      w_count_ext;

    logic                     r_rsp_valid;
    logic [STATUS_W-1:0]      r_status;
    logic signed [VAL_W-1:0]  r_head_value;
    logic [PRIO_W-1:0]        r_head_prio;
    logic signed [VAL_W-1:0]  r_rem_value;
    logic [PRIO_W-1:0]        r_rem_prio;
    logic [CNT_W-1:0]         r_rsp_count;

    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_FULL);

    always_comb begin
        w_ctrl   = '{ins: 1'b0, rem: 1'b0, value: i_cmd.item_value,
                     prio: i_cmd.item_priority};
        w_status = STATUS_OK;
        n_count  = r_count;
        unique case (i_cmd.command)
            CMD_INSERT: begin
                if (w_full) begin
                    w_status = STATUS_OVERFLOW;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    w_status = STATUS_UNDERFLOW;
                end else begin
                    w_ctrl.rem = w_accept;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                // query and the unused code change nothing
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_before;

        if (g == 0) begin : g_head
            assign w_left        = '0;
            assign w_left_before = 1'b0;
        end else begin : g_body
            assign w_left        = w_entry[g-1];
            assign w_left_before = w_before[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left        (w_left),
            .i_left_before (w_left_before),
            .i_right       (w_right),
            .o_entry       (w_entry[g]),
            .o_next        (w_next[g]),
            .o_before      (w_before[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transfer in.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_head_value <= w_next[0].valid ? w_next[0].value : '0;
            r_head_prio  <= w_next[0].valid ? w_next[0].prio : '0;
            r_rem_value  <= w_ctrl.rem ? w_entry[0].value : '0;
            r_rem_prio   <= w_ctrl.rem ? w_entry[0].prio : '0;
            r_rsp_count  <= n_count;
        end
    end

    assign w_count_ext = 32'(r_rsp_count);

    assign o_rsp.valid            = r_rsp_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.head_value       = r_head_value;
    assign o_rsp.head_priority    = r_head_prio;
    assign o_rsp.removed_value    = r_rem_value;
    assign o_rsp.removed_priority = r_rem_prio;
    assign o_rsp.entry_count      = w_count_ext[COUNT_OUT_W-1:0];
    assign o_rsp.is_empty         = (r_rsp_count == '0);
    assign o_rsp.is_full          = (r_rsp_count == CNT_FULL);

`ifndef ASSERT_OFF
    a_head_valid_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].valid == (r_count != '0))
        else $error("head slot valid disagrees with stored count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry[0].valid && w_entry[1].valid) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("first two slots out of priority order");

    a_overflow_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.command == CMD_INSERT) && w_full) |=> $stable(r_count))
        else $error("rejected insert changed the count");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_rsp_count == '0)) |-> ((r_head_value == '0) && (r_head_prio == '0)))
        else $error("empty result reports a nonzero head");
`endif

endmodule
